FILE: rtl/core/qrs_pkg.sv
// Package for the quadratic root solver: default sizes and status codes.
package qrs_pkg;

  // Default coefficient format, signed Q16.16.
  localparam int unsigned CoefWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  // Status codes on the result channel.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNegDisc  = 2'd1;
  localparam logic [1:0] StatusZeroA    = 2'd2;
  localparam logic [1:0] StatusSat      = 2'd3;

endpackage

FILE: rtl/core/qrs_if.sv
// Channel interfaces for the quadratic root solver: coefficient and root transactions.
interface qrs_coef_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] coef_a;
  logic [W-1:0] coef_b;
  logic [W-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] root;
  logic [1:0]   status;

  modport source (output valid, root, status, input ready);
  modport sink   (input valid, root, status, output ready);
endinterface

FILE: rtl/core/qrs_sqrt_cell.sv
// One cell of the square root chain: decides one root bit per item.
module qrs_sqrt_cell #(
  parameter int unsigned TW = 67,
  parameter int unsigned SW = 33,
  parameter int unsigned K  = 0,
  parameter int unsigned XW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [TW-1:0] rem_i,
  input  logic [SW-1:0] root_i,
  input  logic [XW-1:0] side_i,
  output logic          vld_o,
  output logic [TW-1:0] rem_o,
  output logic [SW-1:0] root_o,
  output logic [XW-1:0] side_o
);

  logic [TW-1:0] trial;
  logic          take;
  logic          vld_q;
  logic [TW-1:0] rem_q;
  logic [SW-1:0] root_q;
  logic [XW-1:0] side_q;

  // Growth of the square when this bit is set: 2*R*2^K + 2^(2K).
  always_comb begin
    trial = ({{(TW-SW){1'b0}}, root_i} << (K + 1)) | (TW'(1) << (2 * K));
    take  = (rem_i >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= take ? (rem_i - trial) : rem_i;
      root_q <= take ? (root_i | (SW'(1) << K)) : root_i;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

FILE: rtl/core/qrs_div_cell.sv
// One cell of the divider chain: restoring division, one quotient bit per item.
module qrs_div_cell #(
  parameter int unsigned QW   = 50,
  parameter int unsigned DENW = 33,
  parameter int unsigned I    = 0,
  parameter int unsigned XW   = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [QW-1:0]   num_i,
  input  logic [DENW-1:0] den_i,
  input  logic [DENW-1:0] rem_i,
  input  logic [QW-1:0]   quo_i,
  input  logic [XW-1:0]   side_i,
  output logic            vld_o,
  output logic [QW-1:0]   num_o,
  output logic [DENW-1:0] den_o,
  output logic [DENW-1:0] rem_o,
  output logic [QW-1:0]   quo_o,
  output logic [XW-1:0]   side_o
);

  logic [DENW:0]   shifted;
  logic            take;
  logic [DENW:0]   diff;
  logic            vld_q;
  logic [QW-1:0]   num_q;
  logic [DENW-1:0] den_q;
  logic [DENW-1:0] rem_q;
  logic [QW-1:0]   quo_q;
  logic [XW-1:0]   side_q;

  // Bring down the next numerator bit and try a subtraction.
  always_comb begin
    shifted = {rem_i, num_i[I]};
    take    = (shifted >= {1'b0, den_i});
    diff    = shifted - {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= take ? diff[DENW-1:0] : shifted[DENW-1:0];
      quo_q  <= take ? (quo_i | (QW'(1) << I)) : quo_i;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign side_o = side_q;

endmodule

FILE: rtl/core/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, square root chain, divider chain.
//
// One coefficient transaction (a, b, c, signed fixed point with FRAC_BITS fraction
// bits) on coef_i gives exactly one root transaction (root, status) on root_o.
// The discriminant b*b - 4*a*c is formed exactly, its floor square root is taken
// one bit per cell, and (sqrt - b) / (2a) is found by a restoring divider, one
// quotient bit per cell.
// An item passes two front stages, COEF_WIDTH+1 square root cells, one numerator
// stage, COEF_WIDTH+FRAC_BITS+2 divider cells and the output register; the default
// format is Q16.16. Throughput is one transaction per cycle while the receiver
// takes results; every cell holds one item in flight.
// Status 0 is ok, 1 a negative discriminant, 2 a zero a (root 0 for both), and
// 3 a root clamped to the signed range.
// When the receiver stalls with a result in the output register, the whole chain
// holds and coef_i.ready drops; it rises again as soon as the result is taken.
// Reset clears all valid flags; no item is in flight afterwards.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int unsigned COEF_WIDTH = CoefWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  qrs_coef_if.sink   coef_i,
  qrs_root_if.source root_o
);

  localparam int unsigned W     = COEF_WIDTH;
  localparam int unsigned SW    = W + 1;
  localparam int unsigned TW    = 2 * SW + 1;
  localparam int unsigned NW    = W + 2;
  localparam int unsigned QW    = NW + FRAC_BITS;
  localparam int unsigned DENW  = W + 1;
  localparam int unsigned SQ_XW = 2 + 2 + 2 * W;
  localparam int unsigned DV_XW = 3;

  logic en;
  logic out_vld_q;

  // The chain advances unless a result waits in the output register and the receiver is not ready.
  assign en           = !out_vld_q || root_o.ready;
  assign coef_i.ready = en;

  // Stage A: magnitudes and the two products.
  logic         a_neg, b_neg, c_neg;
  logic [W-1:0] a_mag, b_mag, c_mag;
  logic         sa_vld_q;
  logic [2*W-1:0] sa_bb_q, sa_ac_q;
  logic         sa_na_q, sa_nb_q, sa_nc_q, sa_zero_q;
  logic [W-1:0] sa_ma_q, sa_mb_q;

  always_comb begin
    a_neg = coef_i.coef_a[W-1];
    b_neg = coef_i.coef_b[W-1];
    c_neg = coef_i.coef_c[W-1];
    a_mag = a_neg ? (~coef_i.coef_a + W'(1)) : coef_i.coef_a;
    b_mag = b_neg ? (~coef_i.coef_b + W'(1)) : coef_i.coef_b;
    c_mag = c_neg ? (~coef_i.coef_c + W'(1)) : coef_i.coef_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= coef_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_bb_q   <= {{W{1'b0}}, b_mag} * {{W{1'b0}}, b_mag};
      sa_ac_q   <= {{W{1'b0}}, a_mag} * {{W{1'b0}}, c_mag};
      sa_na_q   <= a_neg;
      sa_nb_q   <= b_neg;
      sa_nc_q   <= c_neg;
      sa_zero_q <= (a_mag == '0);
      sa_ma_q   <= a_mag;
      sa_mb_q   <= b_mag;
    end
  end

  // Stage B: discriminant and early status.
  logic [2*W+1:0] bb_x, ac4_x, disc;
  logic           disc_neg;
  logic [1:0]     pre_status;
  logic           sb_vld_q;
  logic [TW-1:0]  sb_disc_q;
  logic [SQ_XW-1:0] sb_side_q;

  always_comb begin
    bb_x     = {2'b00, sa_bb_q};
    ac4_x    = {sa_ac_q, 2'b00};
    disc_neg = (sa_na_q == sa_nc_q) && (bb_x < ac4_x);
    disc     = (sa_na_q != sa_nc_q) ? (bb_x + ac4_x) : (bb_x - ac4_x);
    if (sa_zero_q) begin
      pre_status = StatusZeroA;
    end else if (disc_neg) begin
      pre_status = StatusNegDisc;
    end else begin
      pre_status = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
    end else if (en) begin
      sb_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_disc_q <= {{(TW-2*W-2){1'b0}}, disc};
      sb_side_q <= {pre_status, sa_na_q, sa_nb_q, sa_ma_q, sa_mb_q};
    end
  end

  // Square root chain, most significant root bit first.
  logic             sq_vld  [SW+1];
  logic [TW-1:0]    sq_rem  [SW+1];
  logic [SW-1:0]    sq_root [SW+1];
  logic [SQ_XW-1:0] sq_side [SW+1];

  assign sq_vld[0]  = sb_vld_q;
  assign sq_rem[0]  = sb_disc_q;
  assign sq_root[0] = '0;
  assign sq_side[0] = sb_side_q;

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    qrs_sqrt_cell #(
      .TW (TW),
      .SW (SW),
      .K  (SW - 1 - j),
      .XW (SQ_XW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .side_i (sq_side[j]),
      .vld_o  (sq_vld[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .side_o (sq_side[j+1])
    );
  end

  // Stage C: signed numerator sqrt - b as magnitude and sign.
  logic [1:0]    c_status;
  logic          c_na, c_nb;
  logic [W-1:0]  c_ma, c_mb;
  logic [NW-1:0] s_x, mb_x, mn;
  logic          nn;
  logic          sc_vld_q;
  logic [QW-1:0] sc_num_q;
  logic [DENW-1:0] sc_den_q;
  logic [DV_XW-1:0] sc_side_q;

  always_comb begin
    {c_status, c_na, c_nb, c_ma, c_mb} = sq_side[SW];
    s_x  = {1'b0, sq_root[SW]};
    mb_x = {2'b00, c_mb};
    if (c_nb) begin
      mn = s_x + mb_x;
      nn = 1'b0;
    end else if (s_x >= mb_x) begin
      mn = s_x - mb_x;
      nn = 1'b0;
    end else begin
      mn = mb_x - s_x;
      nn = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else if (en) begin
      sc_vld_q <= sq_vld[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_num_q  <= {mn, {FRAC_BITS{1'b0}}};
      sc_den_q  <= {c_ma, 1'b0};
      sc_side_q <= {c_status, nn ^ c_na};
    end
  end

  // Divider chain, most significant quotient bit first.
  logic             dv_vld  [QW+1];
  logic [QW-1:0]    dv_num  [QW+1];
  logic [DENW-1:0]  dv_den  [QW+1];
  logic [DENW-1:0]  dv_rem  [QW+1];
  logic [QW-1:0]    dv_quo  [QW+1];
  logic [DV_XW-1:0] dv_side [QW+1];

  assign dv_vld[0]  = sc_vld_q;
  assign dv_num[0]  = sc_num_q;
  assign dv_den[0]  = sc_den_q;
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = sc_side_q;

  for (genvar j = 0; j < QW; j++) begin : g_div
    qrs_div_cell #(
      .QW   (QW),
      .DENW (DENW),
      .I    (QW - 1 - j),
      .XW   (DV_XW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_vld[j]),
      .num_i  (dv_num[j]),
      .den_i  (dv_den[j]),
      .rem_i  (dv_rem[j]),
      .quo_i  (dv_quo[j]),
      .side_i (dv_side[j]),
      .vld_o  (dv_vld[j+1]),
      .num_o  (dv_num[j+1]),
      .den_o  (dv_den[j+1]),
      .rem_o  (dv_rem[j+1]),
      .quo_o  (dv_quo[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // Output stage: sign, saturation and special cases.
  logic [1:0]    f_status;
  logic          f_sgn, nr;
  logic [QW-1:0] q, lim;
  logic [W-1:0]  root_d;
  logic [1:0]    status_d;
  logic [W-1:0]  out_root_q;
  logic [1:0]    out_status_q;

  always_comb begin
    {f_status, f_sgn} = dv_side[QW];
    q   = dv_quo[QW];
    nr  = f_sgn && (q != '0);
    lim = nr ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    if (f_status != StatusOk) begin
      root_d   = '0;
      status_d = f_status;
    end else if (q > lim) begin
      root_d   = lim[W-1:0];
      status_d = StatusSat;
    end else begin
      root_d   = nr ? (~q[W-1:0] + W'(1)) : q[W-1:0];
      status_d = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_root_q   <= root_d;
      out_status_q <= status_d;
    end
  end

  assign root_o.valid  = out_vld_q;
  assign root_o.root   = out_root_q;
  assign root_o.status = out_status_q;

endmodule

FILE: sim/tb_quadratic_root_solver.sv
// Testbench for the quadratic root solver: random and directed coefficient sets checked by a scoreboard.
`timescale 1ns / 100ps

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int unsigned CW = CoefWidthDef;
  localparam int unsigned FB = FracBitsDef;
  localparam int unsigned Latency = 2 * CW + FB + 7;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [CW-1:0] root;
    logic [1:0]    status;
  } root_t;

  // Computes the expected root of one coefficient set, exact wide arithmetic.
  function automatic root_t solve_root(logic [CW-1:0] a, logic [CW-1:0] b,
                                       logic [CW-1:0] c);
    logic signed [CW-1:0] sa, sb, sc;
    logic [CW-1:0] ma, mb, mc;
    logic [2*CW+3:0] bb, ac4, disc;
    logic [CW+1:0] sq, mn;
    logic [CW+1:0] cand;
    logic [2*CW+3:0] num, q;
    logic [CW:0] den;
    logic nn, nr;
    logic [2*CW+3:0] lim;
    root_t r;
    sa = a; sb = b; sc = c;
    ma = sa[CW-1] ? -a : a;
    mb = sb[CW-1] ? -b : b;
    mc = sc[CW-1] ? -c : c;
    if (ma == '0) begin
      r.root = '0;
      r.status = StatusZeroA;
      return r;
    end
    bb = mb * mb;
    ac4 = (ma * mc) << 2;
    if (sa[CW-1] != sc[CW-1]) begin
      disc = bb + ac4;
    end else begin
      if (bb < ac4) begin
        r.root = '0;
        r.status = StatusNegDisc;
        return r;
      end
      disc = bb - ac4;
    end
    sq = '0;
    for (int k = CW + 1; k >= 0; k--) begin
      cand = sq | ((CW + 2)'(1) << k);
      if ((2*CW+4)'(cand) * (2*CW+4)'(cand) <= disc) sq = cand;
    end
    if (sb[CW-1]) begin
      mn = sq + mb; nn = 1'b0;
    end else if (sq >= mb) begin
      mn = sq - mb; nn = 1'b0;
    end else begin
      mn = mb - sq; nn = 1'b1;
    end
    num = (2*CW+4)'(mn) << FB;
    den = {ma, 1'b0};
    q = num / den;
    nr = (nn != sa[CW-1]) && (q != 0);
    lim = nr ? (2*CW+4)'(1) << (CW - 1) : ((2*CW+4)'(1) << (CW - 1)) - 1;
    if (q > lim) begin
      r.root = nr ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      r.status = StatusSat;
    end else begin
      r.root = nr ? -q[CW-1:0] : q[CW-1:0];
      r.status = StatusOk;
    end
    return r;
  endfunction

  // Holds the roots still awaited and compares arrivals against them.
  class root_scoreboard;
    root_t pending_roots[$];
    int errors = 0;

    function void note_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
      pending_roots.push_back(solve_root(a, b, c));
    endfunction

    function void check_root(root_t got);
      root_t exp_r;
      if (pending_roots.size() == 0) begin
        report_error($sformatf("unexpected root %h status %0d", got.root, got.status));
        return;
      end
      exp_r = pending_roots.pop_front();
      if (got.root !== exp_r.root)
        report_error($sformatf("root %h, wanted %h", got.root, exp_r.root));
      if (got.status !== exp_r.status)
        report_error($sformatf("status %0d, wanted %0d", got.status, exp_r.status));
    endfunction

    function void report_error(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  root_scoreboard sb_q;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  logic timed_out;

  qrs_coef_if #(.W(CW)) coef_ch ();
  qrs_root_if #(.W(CW)) root_ch ();

  quadratic_root_solver u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .coef_i(coef_ch.sink),
    .root_o(root_ch.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Accepted transactions on both channels go to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && coef_ch.valid && coef_ch.ready)
      sb_q.note_coefs(coef_ch.coef_a, coef_ch.coef_b, coef_ch.coef_c);
    if (rst_ni && root_ch.valid && root_ch.ready)
      sb_q.check_root('{root: root_ch.root, status: root_ch.status});
  end

  // The receiver stalls at random.
  always @(posedge clk_i) begin
    root_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit && !timed_out) begin
      timed_out <= 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sends one coefficient set, with random gaps before it.
  task automatic send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      coef_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    coef_ch.valid  <= 1'b1;
    coef_ch.coef_a <= a;
    coef_ch.coef_b <= b;
    coef_ch.coef_c <= c;
    @(posedge clk_i);
    while (!coef_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    coef_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb_q.pending_roots.size() != 0) @(posedge clk_i);
  endtask

  // Random field value, often near interesting magnitudes.
  function automatic logic [CW-1:0] pick_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return CW'($signed($urandom_range(16'hffff)) - 32'sd32768);
      2: return $urandom_range(1) ? CW'($urandom_range(1 << 20)) : -CW'($urandom_range(1 << 20));
      3: return {$urandom_range(1) ? 1'b1 : 1'b0, {(CW-1){$urandom_range(1) ? 1'b1 : 1'b0}}};
      default: return CW'($signed($urandom_range(32'h0003_ffff)) - 32'sd131072) << 8;
    endcase
  endfunction

  // Builds a set from chosen integer roots so the discriminant is non-negative.
  task automatic send_real_roots();
    int signed r1, r2, k;
    logic signed [63:0] a, b, c;
    r1 = $signed($urandom_range(200)) - 100;
    r2 = $signed($urandom_range(200)) - 100;
    k = $signed($urandom_range(8)) - 4;
    if (k == 0) k = 1;
    a = 64'(k) <<< FB;
    b = -(64'(k) * (r1 + r2)) <<< FB;
    c = (64'(k) * r1 * r2) <<< FB;
    send_coefs(a[CW-1:0], b[CW-1:0], c[CW-1:0]);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 60) send_real_roots();
      else send_coefs(pick_coef(), pick_coef(), $urandom_range(7) == 0 ? '0 : pick_coef());
    end
  endtask

  localparam logic [CW-1:0] MaxPos = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MaxNeg = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] One = CW'(1) << FB;

  initial begin
    sb_q = new();
    rst_ni = 1'b0;
    coef_ch.valid = 1'b0;
    coef_ch.coef_a = '0;
    coef_ch.coef_b = '0;
    coef_ch.coef_c = '0;
    root_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero a, negative and zero discriminant, saturation, extremes.
    send_coefs('0, One, One);
    send_coefs('0, MaxNeg, MaxPos);
    send_coefs(One, '0, One);
    send_coefs(One, CW'(2) << FB, One);
    send_coefs(One, -(CW'(3) << FB), CW'(2) << FB);
    send_coefs(-One, '0, CW'(4) << FB);
    send_coefs(CW'(1), MaxPos, '0);
    send_coefs(CW'(1), MaxNeg, '0);
    send_coefs(-CW'(1), MaxNeg, MaxPos);
    send_coefs(MaxNeg, MaxNeg, MaxNeg);
    send_coefs(MaxPos, MaxPos, MaxPos);
    send_coefs(MaxNeg, MaxPos, MaxNeg);
    send_coefs(MaxPos, '0, MaxNeg);
    send_coefs('1, '1, '1);
    send_coefs(CW'(1), '0, '1);
    send_coefs(MaxNeg, '0, '0);
    send_coefs(One, '0, '0);
    send_coefs(-One, MaxPos, MaxPos);
    wait_drained();

    send_idle_pct = 34;
    recv_idle_pct = 75;
    random_phase(430);
    wait_drained();
    send_idle_pct = 75;
    recv_idle_pct = 34;
    random_phase(430);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(430);
    wait_drained();
    repeat (Latency + 20) @(posedge clk_i);

    if (sb_q.errors == 0 && sb_q.pending_roots.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
